### rtl/bss_pkg.sv
// Shared types, constants and helpers of the bounded set store.
package bss_pkg;

  localparam int SET_DEPTH   = 32;
  localparam int CNT_W       = $clog2(SET_DEPTH + 1);
  localparam int IDX_W       = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int ELEM_W      = 32;
  localparam int COUNT_W     = 6;
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_UNION  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INTER  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DIFF   = 3'd5;

  localparam logic [STATUS_W-1:0] STAT_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_DUP  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_ELEM = 2'd3;

  typedef enum logic [2:0] {
    OP_INSERT,
    OP_QUERY,
    OP_CLEAR,
    OP_UNION,
    OP_INTER,
    OP_DIFF,
    OP_NOP
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SIZE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    op_e                      op;
    logic                     sel;
    logic signed [ELEM_W-1:0] element;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic                     found;
    logic                     has_element;
    logic signed [ELEM_W-1:0] result_element;
    logic                     last;
    logic [COUNT_W-1:0]       count;
  } res_t;

  // Set sizes are reported modulo 64.
  function automatic logic [COUNT_W-1:0] to_count(input logic [CNT_W-1:0] c);
    logic [CNT_W+COUNT_W-1:0] w;
    w = (CNT_W + COUNT_W)'(c);
    return w[COUNT_W-1:0];
  endfunction

endpackage

### rtl/bounded_set_store_with_set_ops_top.sv
// Top level of the bounded set store with union, intersection and difference.
//
//  channel  | dir | tdata (low bit up)                               | tlast
//  s_axis   | in  | command[2:0] set_select[3] element[35:4] 0[39:36] | -
//  m_axis   | out | status[1:0] found[2] has_element[3]              | last
//           |     | result_element[35:4] count[41:36] 0[47:42]       |
//
// Insert, query, clear: executed in the execution unit at issue from the queue head.
// Union/intersection/difference: an issue step, a scan (one entry per cycle
// against all lanes of the other set), a sizing step, then a walk over A and
// then B that gives one result each time one qualifies and tready allows.
// Reset empties both sets at once; no clearing pass.
// The two-entry command queue accepts until full while results stall downstream.
module bounded_set_store_with_set_ops_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // command[2:0], set_select[3], element[35:4], zero pad
  input  logic [bss_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // status[1:0], found[2], has_element[3], result_element[35:4], count[41:36], zero pad
  output logic [bss_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tlast
);
  import bss_pkg::*;

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;
  res_t res;

  bss_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .q_valid_o (q_valid),
    .q_cmd_o   (q_cmd),
    .q_pop_i   (q_pop)
  );

  bss_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - COUNT_W - ELEM_W - 4)'(0), res.count,
                         res.result_element, res.has_element, res.found, res.status};
  assign m_axis_tlast = res.last;

endmodule

### rtl/bss_front.sv
// Command intake: decodes input transfers and buffers them in a two-entry queue.
module bss_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_valid_i,
  output logic                           s_ready_o,
  input  logic [bss_pkg::IN_TDATA_W-1:0] s_data_i,
  output logic                           q_valid_o,
  output bss_pkg::cmd_t                  q_cmd_o,
  input  logic                           q_pop_i
);
  import bss_pkg::*;

  cmd_t        slot_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  fill_q, fill_d;
  logic        push;
  cmd_t        dec;

  always_comb begin
    case (s_data_i[CMD_W-1:0])
      CMD_INSERT: dec.op = OP_INSERT;
      CMD_QUERY:  dec.op = OP_QUERY;
      CMD_CLEAR:  dec.op = OP_CLEAR;
      CMD_UNION:  dec.op = OP_UNION;
      CMD_INTER:  dec.op = OP_INTER;
      CMD_DIFF:   dec.op = OP_DIFF;
      default:    dec.op = OP_NOP;
    endcase
    dec.sel     = s_data_i[CMD_W];
    dec.element = s_data_i[CMD_W+ELEM_W:CMD_W+1];
  end

  assign s_ready_o = (fill_q != 2'd2);
  assign push      = s_valid_i && s_ready_o;
  assign q_valid_o = (fill_q != 2'd0);
  assign q_cmd_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = q_pop_i ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !q_pop_i) begin
      fill_d = fill_q + 2'd1;
    end else if (!push && q_pop_i) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

endmodule

### rtl/bss_back.sv
// Execution unit: holds both sets, runs commands and drives the result register.
module bss_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  bss_pkg::cmd_t q_cmd_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bss_pkg::res_t out_res_o
);
  import bss_pkg::*;

  logic signed [ELEM_W-1:0] a_q [SET_DEPTH];
  logic signed [ELEM_W-1:0] b_q [SET_DEPTH];

  logic [CNT_W-1:0]     cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  state_e               state_q, state_d;
  op_e                  op_q, op_d;
  logic [IDX_W-1:0]     ptr_q, ptr_d;
  logic                 in_b_q, in_b_d;
  logic [SET_DEPTH-1:0] mark_a_q, mark_a_d, mark_b_q, mark_b_d;
  logic [CNT_W-1:0]     n_inter_q, n_inter_d, n_bx_q, n_bx_d;
  logic [CNT_W-1:0]     rn_q, rn_d, emitted_q, emitted_d;
  res_t                 res_q, res_d;
  logic                 out_valid_q, out_valid_d;
  logic                 we_a, we_b;

  logic [SET_DEPTH-1:0] valid_a, valid_b, eq_a, eq_b;
  logic signed [ELEM_W-1:0] cur_a, cur_b, key_a, key_b;
  logic                 hit_a, hit_b, hit_sel;
  logic [CNT_W-1:0]     cnt_sel, ptr_ext, max_cnt;
  logic [CNT_W:0]       ptr_inc, union_sum;
  logic                 out_free, issue, is_setop, scan_done;
  logic                 cand_valid, qual, emit_fire, emit_last;

  assign cur_a = a_q[ptr_q];
  assign cur_b = b_q[ptr_q];
  // Scan compares each set's entry at ptr against every lane of the other set.
  assign key_a = (state_q == ST_SCAN) ? cur_b : q_cmd_i.element;
  assign key_b = (state_q == ST_SCAN) ? cur_a : q_cmd_i.element;

  for (genvar i = 0; i < SET_DEPTH; i++) begin : g_lane
    assign valid_a[i] = CNT_W'(i) < cnt_a_q;
    assign valid_b[i] = CNT_W'(i) < cnt_b_q;
    assign eq_a[i]    = (a_q[i] == key_a);
    assign eq_b[i]    = (b_q[i] == key_b);
  end

  assign hit_a   = |(eq_a & valid_a);
  assign hit_b   = |(eq_b & valid_b);
  assign hit_sel = q_cmd_i.sel ? hit_b : hit_a;
  assign cnt_sel = q_cmd_i.sel ? cnt_b_q : cnt_a_q;

  assign ptr_ext   = CNT_W'(ptr_q);
  assign ptr_inc   = (CNT_W + 1)'(ptr_ext) + (CNT_W + 1)'(1);
  assign max_cnt   = (cnt_a_q > cnt_b_q) ? cnt_a_q : cnt_b_q;
  assign scan_done = (ptr_inc >= (CNT_W + 1)'(max_cnt)) ||
                     (ptr_q == IDX_W'(SET_DEPTH - 1));
  assign union_sum = (CNT_W + 1)'(cnt_a_q) + (CNT_W + 1)'(n_bx_q);

  assign out_free = !out_valid_q || out_ready_i;
  assign issue    = (state_q == ST_IDLE) && q_valid_i && out_free;
  assign is_setop = (q_cmd_i.op == OP_UNION) || (q_cmd_i.op == OP_INTER) ||
                    (q_cmd_i.op == OP_DIFF);

  assign cand_valid = in_b_q ? (ptr_ext < cnt_b_q) : (ptr_ext < cnt_a_q);

  always_comb begin
    case (op_q)
      OP_UNION: qual = in_b_q ? !mark_b_q[ptr_q] : 1'b1;
      OP_INTER: qual = !in_b_q && mark_a_q[ptr_q];
      OP_DIFF:  qual = !in_b_q && !mark_a_q[ptr_q];
      default:  qual = 1'b0;
    endcase
    qual = qual && cand_valid;
  end

  assign emit_fire = (state_q == ST_EMIT) && out_free && ((rn_q == '0) || qual);
  assign emit_last = (rn_q == '0) || ((emitted_q + CNT_W'(1)) == rn_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (issue && is_setop) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_SIZE;
        end
      end
      ST_SIZE: state_d = ST_EMIT;
      ST_EMIT: begin
        if (emit_fire && emit_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    cnt_a_d     = cnt_a_q;
    cnt_b_d     = cnt_b_q;
    op_d        = op_q;
    ptr_d       = ptr_q;
    in_b_d      = in_b_q;
    mark_a_d    = mark_a_q;
    mark_b_d    = mark_b_q;
    n_inter_d   = n_inter_q;
    n_bx_d      = n_bx_q;
    rn_d        = rn_q;
    emitted_d   = emitted_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    we_a        = 1'b0;
    we_b        = 1'b0;
    q_pop_o     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (issue) begin
          q_pop_o = 1'b1;
          res_d   = '0;
          res_d.status = STAT_DONE;
          res_d.last   = 1'b1;
          res_d.count  = to_count(cnt_sel);
          case (q_cmd_i.op)
            OP_INSERT: begin
              if (hit_sel) begin
                res_d.status = STAT_DUP;
              end else if (cnt_sel < CNT_W'(SET_DEPTH)) begin
                res_d.count = to_count(cnt_sel + CNT_W'(1));
                if (q_cmd_i.sel) begin
                  we_b    = 1'b1;
                  cnt_b_d = cnt_b_q + CNT_W'(1);
                end else begin
                  we_a    = 1'b1;
                  cnt_a_d = cnt_a_q + CNT_W'(1);
                end
              end else begin
                res_d.status = STAT_FULL;
              end
            end
            OP_QUERY: res_d.found = hit_sel;
            OP_CLEAR: begin
              res_d.count = '0;
              if (q_cmd_i.sel) begin
                cnt_b_d = '0;
              end else begin
                cnt_a_d = '0;
              end
            end
            OP_UNION, OP_INTER, OP_DIFF: begin
              op_d      = q_cmd_i.op;
              ptr_d     = '0;
              n_inter_d = '0;
              n_bx_d    = '0;
            end
            default: ;
          endcase
          out_valid_d = !is_setop;
        end
      end
      ST_SCAN: begin
        if (ptr_ext < cnt_a_q) begin
          mark_a_d[ptr_q] = hit_b;
          if (hit_b) begin
            n_inter_d = n_inter_q + CNT_W'(1);
          end
        end
        if (ptr_ext < cnt_b_q) begin
          mark_b_d[ptr_q] = hit_a;
          if (!hit_a) begin
            n_bx_d = n_bx_q + CNT_W'(1);
          end
        end
        if (scan_done) begin
          ptr_d     = '0;
          in_b_d    = 1'b0;
          emitted_d = '0;
        end else begin
          ptr_d = ptr_q + IDX_W'(1);
        end
      end
      ST_SIZE: begin
        case (op_q)
          OP_UNION: begin
            if (union_sum > (CNT_W + 1)'(SET_DEPTH)) begin
              rn_d = CNT_W'(SET_DEPTH);
            end else begin
              rn_d = union_sum[CNT_W-1:0];
            end
          end
          OP_INTER: rn_d = n_inter_q;
          default:  rn_d = cnt_a_q - n_inter_q;
        endcase
      end
      ST_EMIT: begin
        if (emit_fire) begin
          out_valid_d = 1'b1;
          res_d       = '0;
          res_d.last  = emit_last;
          if (rn_q != '0) begin
            res_d.status         = STAT_ELEM;
            res_d.has_element    = 1'b1;
            res_d.result_element = in_b_q ? cur_b : cur_a;
            res_d.count          = to_count(rn_q);
            emitted_d            = emitted_q + CNT_W'(1);
          end
        end
        // A waiting candidate holds the pointer; skipped entries move on.
        if ((rn_q != '0) && (!qual || out_free)) begin
          if (!in_b_q && (ptr_inc >= (CNT_W + 1)'(cnt_a_q))) begin
            in_b_d = 1'b1;
            ptr_d  = '0;
          end else begin
            ptr_d = ptr_q + IDX_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we_a) begin
      a_q[cnt_a_q[IDX_W-1:0]] <= q_cmd_i.element;
    end
    if (we_b) begin
      b_q[cnt_b_q[IDX_W-1:0]] <= q_cmd_i.element;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    ptr_q     <= ptr_d;
    in_b_q    <= in_b_d;
    mark_a_q  <= mark_a_d;
    mark_b_q  <= mark_b_d;
    n_inter_q <= n_inter_d;
    n_bx_q    <= n_bx_d;
    rn_q      <= rn_d;
    emitted_q <= emitted_d;
    res_q     <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_a_q     <= cnt_a_d;
      cnt_b_q     <= cnt_b_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_a_q <= CNT_W'(SET_DEPTH)) && (cnt_b_q <= CNT_W'(SET_DEPTH)))
    else $error("set size above capacity");

  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && rn_q != '0) |-> (emitted_q < rn_q))
    else $error("emitted more results than the result size");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_fire && emit_last) |=> (state_q == ST_IDLE && out_valid_q && res_q.last))
    else $error("final result did not end the set operation");

  a_setop_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && is_setop) |=> (state_q == ST_SCAN && ptr_q == '0))
    else $error("set operation did not start its scan");
`endif

endmodule
